// ===== design/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property wrappers, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and character constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int IDX_W = 11;

    typedef logic [1:0]  t_kind;
    typedef logic [7:0]  t_char;
    typedef logic [63:0] t_hex;
    typedef logic [10:0] t_index;
    typedef logic [4:0]  t_row_out;
    typedef logic [6:0]  t_col_out;
    typedef logic [3:0]  t_color4;
    typedef logic [1:0]  t_cfg_idx;

    typedef struct packed {
        t_char chr;
        t_char color;
    } t_cell;

    localparam t_kind KIND_PUTC  = 2'd0;
    localparam t_kind KIND_PUTX  = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;
    localparam t_kind KIND_READ  = 2'd3;

    localparam t_cfg_idx CFG_FG = 2'd0;
    localparam t_cfg_idx CFG_BG = 2'd1;

    localparam t_char CH_NL      = 8'h0A;
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_X       = 8'h78;

    localparam t_char   COLOR_RESET = 8'h0F;
    localparam t_color4 FG_RESET    = 4'hF;
    localparam t_color4 BG_RESET    = 4'h0;
    localparam logic [3:0] NIB_LAST = 4'd15;
    localparam logic [3:0] NIB_TEN  = 4'hA;

    // Uppercase ASCII hex digit of one nibble.
    function automatic t_char hex_char(input logic [3:0] d);
        t_char c;
        if (d >= NIB_TEN) begin
            c = CH_UPPER_A + t_char'(d - NIB_TEN);
        end else begin
            c = CH_ZERO + t_char'(d);
        end
        return c;
    endfunction

endpackage

// ===== design/tcw_in_if.sv =====
// ----------------------------------------------------------------------------
// tcw_in_if
// Command channel: valid/ready plus one console command.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic             valid;
    logic             ready;
    tcw_pkg::t_kind   kind;
    tcw_pkg::t_char   char_code;
    tcw_pkg::t_hex    hex_value;
    tcw_pkg::t_index  cell_index;

    modport source (output valid, output kind, output char_code, output hex_value,
                     output cell_index, input ready);
    modport sink   (input valid, input kind, input char_code, input hex_value,
                     input cell_index, output ready);
endinterface

// ===== design/tcw_out_if.sv =====
// ----------------------------------------------------------------------------
// tcw_out_if
// Result channel: valid/ready plus cursor position and read cell.
// ----------------------------------------------------------------------------
interface tcw_out_if;
    logic               valid;
    logic               ready;
    tcw_pkg::t_row_out  cursor_row;
    tcw_pkg::t_col_out  cursor_col;
    tcw_pkg::t_char     cell_char;
    tcw_pkg::t_char     cell_color;

    modport source (output valid, output cursor_row, output cursor_col,
                     output cell_char, output cell_color, input ready);
    modport sink   (input valid, input cursor_row, input cursor_col,
                     input cell_char, input cell_color, output ready);
endinterface

// ===== design/tcw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tcw_cfg_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
    logic                valid;
    logic                ready;
    tcw_pkg::t_cfg_idx   idx;
    tcw_pkg::t_color4    data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: cursor, deferred wrap, scrolling, hex print, clear and read
// over a ROWS x COLUMNS cell store held in one RAM.
// ----------------------------------------------------------------------------
// Put char, newline and read each end in S_DONE; a pending wrap first moves the
//   cursor to a new line, a scroll first blanks a row; clear sweeps every cell.
// Put hex prints the prefix, skips leading zero nibbles, then prints each digit.
// One command at a time: the next is taken only after the result loads, which
//   waits while the output holds a result that is not yet taken.
// Reset: a clearing pass writes spaces in colour 0x0F over every cell; no command
//   is accepted until it ends, register writes are taken throughout.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out,
    tcw_cfg_if.sink    i_cfg
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int AW1   = AW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int SW    = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;

    localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - COLUMNS);
    localparam logic [AW:0]   CELLS_W       = AW1'(CELLS);
    localparam logic [SW-1:0] CELLS_S       = SW'(CELLS);
    localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
    localparam logic [CW-1:0] COLS_C        = CW'(COLUMNS);

    // Sequencer states
    localparam logic [2:0] S_INIT  = 3'd0;  // clearing pass after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a command
    localparam logic [2:0] S_CHAR  = 3'd2;  // place one character
    localparam logic [2:0] S_BLANK = 3'd3;  // blank the row that scrolled in
    localparam logic [2:0] S_HEX   = 3'd4;  // pick the next hex digit
    localparam logic [2:0] S_CLEAR = 3'd5;  // fill the whole screen
    localparam logic [2:0] S_READ  = 3'd6;  // issue the cell read
    localparam logic [2:0] S_DONE  = 3'd7;  // hand the result to the output

    // Character source of the current command
    localparam logic [1:0] ST_ONE = 2'd0;   // single put char
    localparam logic [1:0] ST_P0  = 2'd1;   // hex prefix '0'
    localparam logic [1:0] ST_PX  = 2'd2;   // hex prefix 'x'
    localparam logic [1:0] ST_DIG = 2'd3;   // hex digits

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]        r_state,      n_state;
    logic [AW-1:0]     r_sweep_addr, n_sweep_addr;
    logic [AW-1:0]     r_sweep_end,  n_sweep_end;
    logic [RW-1:0]     r_row,        n_row;
    logic [CW-1:0]     r_col,        n_col;
    logic [AW-1:0]     r_row_base,   n_row_base;   // r_row * COLUMNS
    logic [AW-1:0]     r_top_base,   n_top_base;   // physical start of row 0
    tcw_pkg::t_color4  r_fg,         n_fg;
    tcw_pkg::t_color4  r_bg,         n_bg;
    tcw_pkg::t_kind    r_kind,       n_kind;
    tcw_pkg::t_char    r_ch,         n_ch;
    tcw_pkg::t_hex     r_hex,        n_hex;
    tcw_pkg::t_index   r_idx,        n_idx;
    logic [1:0]        r_stage,      n_stage;
    logic [3:0]        r_nib,        n_nib;        // nibbles left after the top one
    logic              r_lead,       n_lead;
    logic              r_out_valid,  n_out_valid;
    tcw_pkg::t_row_out r_out_row,    n_out_row;
    tcw_pkg::t_col_out r_out_col,    n_out_col;
    tcw_pkg::t_char    r_out_char,   n_out_char;
    tcw_pkg::t_char    r_out_color,  n_out_color;

    // ------------------------------------------------------------------
    // RAM port
    // ------------------------------------------------------------------
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    tcw_pkg::t_cell  w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    tcw_pkg::t_cell  w_rdata;

    tcw_ram #(
        .WIDTH  ($bits(tcw_pkg::t_cell)),
        .DEPTH  (CELLS),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Address arithmetic. The screen is a ring of rows: a scroll moves
    // r_top_base by one row instead of copying cells.
    // ------------------------------------------------------------------
    tcw_pkg::t_char  w_color;
    logic [AW-1:0]   w_pos;
    logic [AW:0]     w_wsum;
    logic [AW-1:0]   w_wphys;
    logic [SW-1:0]   w_rsum;
    logic [AW-1:0]   w_rphys;
    logic            w_idx_ok;
    logic [AW-1:0]   w_top_next;
    logic            w_wrap;
    logic            w_is_nl;
    logic            w_adv;

    assign w_color    = {r_bg, r_fg};
    assign w_pos      = r_row_base + AW'(r_col);
    assign w_wsum     = {1'b0, w_pos} + {1'b0, r_top_base};
    assign w_wphys    = (w_wsum >= CELLS_W) ? AW'(w_wsum - CELLS_W) : AW'(w_wsum);
    assign w_rsum     = SW'(r_idx) + SW'(r_top_base);
    assign w_rphys    = (w_rsum >= CELLS_S) ? AW'(w_rsum - CELLS_S) : AW'(w_rsum);
    assign w_idx_ok   = (SW'(r_idx) < CELLS_S);
    assign w_top_next = (r_top_base == LAST_ROW_BASE) ? '0 : (r_top_base + COLS_A);
    assign w_wrap     = (r_col == COLS_C);
    assign w_is_nl    = (r_ch == tcw_pkg::CH_NL);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_sweep_end  = r_sweep_end;
        n_row        = r_row;
        n_col        = r_col;
        n_row_base   = r_row_base;
        n_top_base   = r_top_base;
        n_fg         = r_fg;
        n_bg         = r_bg;
        n_kind       = r_kind;
        n_ch         = r_ch;
        n_hex        = r_hex;
        n_idx        = r_idx;
        n_stage      = r_stage;
        n_nib        = r_nib;
        n_lead       = r_lead;
        n_out_valid  = r_out_valid;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_char   = r_out_char;
        n_out_color  = r_out_color;
        w_we         = 1'b0;
        w_waddr      = r_sweep_addr;
        w_wdata      = '{chr: tcw_pkg::CH_SPACE, color: w_color};
        w_re         = 1'b0;
        w_raddr      = w_rphys;
        w_adv        = 1'b0;

        // Register writes land at once; the user must send them only while idle, the block does not enforce it.
        if (i_cfg.valid) begin
            case (i_cfg.idx)
                tcw_pkg::CFG_FG: n_fg = i_cfg.data;
                tcw_pkg::CFG_BG: n_bg = i_cfg.data;
                default: ;
            endcase
        end

        // Drop the result once the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                w_we          = 1'b1;
                w_wdata.color = tcw_pkg::COLOR_RESET;
                if (r_sweep_addr == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind = i_in.kind;
                    n_ch   = i_in.char_code;
                    n_hex  = i_in.hex_value;
                    n_idx  = i_in.cell_index;
                    case (i_in.kind)
                        tcw_pkg::KIND_PUTC: begin
                            n_stage = ST_ONE;
                            n_state = S_CHAR;
                        end
                        tcw_pkg::KIND_PUTX: begin
                            n_ch    = tcw_pkg::CH_ZERO;
                            n_stage = ST_P0;
                            n_nib   = tcw_pkg::NIB_LAST;
                            n_state = S_CHAR;
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            n_sweep_addr = '0;
                            n_state      = S_CLEAR;
                        end
                        default: begin
                            n_state = S_READ;
                        end
                    endcase
                end
            end

            S_CHAR: begin
                if (w_is_nl || w_wrap) begin
                    // Newline: explicit, or pending wrap before a printable char
                    n_col = '0;
                    if (r_row != LAST_ROW) begin
                        n_row      = r_row + 1'b1;
                        n_row_base = r_row_base + COLS_A;
                        if (w_is_nl) begin
                            w_adv = 1'b1;
                        end
                    end else begin
                        // Scroll: the old top row becomes the new last row
                        n_top_base   = w_top_next;
                        n_sweep_addr = r_top_base;
                        n_sweep_end  = r_top_base + COLS_A - 1'b1;
                        n_state      = S_BLANK;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_wphys;
                    w_wdata = '{chr: r_ch, color: w_color};
                    n_col   = r_col + 1'b1;
                    w_adv   = 1'b1;
                end
            end

            S_BLANK: begin
                w_we = 1'b1;
                if (r_sweep_addr == r_sweep_end) begin
                    if (w_is_nl) begin
                        w_adv = 1'b1;
                    end else begin
                        n_state = S_CHAR;
                    end
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end

            S_HEX: begin
                // Skip leading zero nibbles, but always print the last one
                if (r_lead && (r_hex[63:60] == 4'h0) && (r_nib != 4'd0)) begin
                    n_hex = {r_hex[59:0], 4'h0};
                    n_nib = r_nib - 1'b1;
                end else begin
                    n_lead  = 1'b0;
                    n_ch    = tcw_pkg::hex_char(r_hex[63:60]);
                    n_state = S_CHAR;
                end
            end

            S_CLEAR: begin
                w_we = 1'b1;
                if (r_sweep_addr == LAST_CELL) begin
                    n_state = S_DONE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end

            S_READ: begin
                w_re    = w_idx_ok;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = tcw_pkg::t_row_out'(r_row);
                    n_out_col   = tcw_pkg::t_col_out'(r_col);
                    if ((r_kind == tcw_pkg::KIND_READ) && w_idx_ok) begin
                        n_out_char  = w_rdata.chr;
                        n_out_color = w_rdata.color;
                    end else begin
                        n_out_char  = '0;
                        n_out_color = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Character finished: advance to the next character of the command
        if (w_adv) begin
            case (r_stage)
                ST_P0: begin
                    n_ch    = tcw_pkg::CH_X;
                    n_stage = ST_PX;
                    n_state = S_CHAR;
                end
                ST_PX: begin
                    n_stage = ST_DIG;
                    n_lead  = 1'b1;
                    n_state = S_HEX;
                end
                ST_DIG: begin
                    if (r_nib == 4'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_hex   = {r_hex[59:0], 4'h0};
                        n_nib   = r_nib - 1'b1;
                        n_state = S_HEX;
                    end
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sweep_addr <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_row_base   <= '0;
            r_top_base   <= '0;
            r_fg         <= tcw_pkg::FG_RESET;
            r_bg         <= tcw_pkg::BG_RESET;
            r_stage      <= ST_ONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_row        <= n_row;
            r_col        <= n_col;
            r_row_base   <= n_row_base;
            r_top_base   <= n_top_base;
            r_fg         <= n_fg;
            r_bg         <= n_bg;
            r_stage      <= n_stage;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        r_sweep_end <= n_sweep_end;
        r_kind      <= n_kind;
        r_ch        <= n_ch;
        r_hex       <= n_hex;
        r_idx       <= n_idx;
        r_nib       <= n_nib;
        r_lead      <= n_lead;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_char  <= n_out_char;
        r_out_color <= n_out_color;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_row = r_out_row;
    assign o_out.cursor_col = r_out_col;
    assign o_out.cell_char  = r_out_char;
    assign o_out.cell_color = r_out_color;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic w_quiet;
    logic w_done_load;

    assign w_quiet     = (r_state == S_IDLE) || (r_state == S_READ) || (r_state == S_DONE);
    assign w_done_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    `TCW_ASSERT_SAME(a_col_range, 1'b1, r_col <= COLS_C, "cursor column past column count")
    `TCW_ASSERT_SAME(a_no_write_when_waiting, w_quiet, !w_we, "cell write in a wait state")
    `TCW_ASSERT_SAME(a_write_in_range, w_we, w_waddr <= LAST_CELL, "cell write beyond screen")
    `TCW_ASSERT_NEXT(a_accept_busy, i_in.valid && i_in.ready, r_state != S_IDLE, "idle after accept")
    `TCW_ASSERT_NEXT(a_done_loads_result, w_done_load, r_out_valid, "no result after finish")

endmodule
